FILE: rtl/assert_macros.svh
// Assertion macros shared by the reorder window modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, disabled in reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// property checked on the next clock
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/srw_pkg.sv
// Package: constants, commands, status codes and control structs
package srw_pkg;
  localparam int WINDOW_DEF = 1024;
  localparam logic [31:0] SEQ_MAX_DEF = 32'hFFFF_FFFF;
  localparam int MAX_PKT_DEF = 2048;
  localparam int TUN_HDR_DEF = 16;
  localparam logic [15:0] OUTER_MIN = 16'd20;
  localparam logic [7:0] TUNNEL_PROTO = 8'd4;
  localparam logic [19:0] TIMEOUT_RESET = 20'd100;

  localparam logic [1:0] CMD_ARRIVE = 2'd0;
  localparam logic [1:0] CMD_DELIVER = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [3:0] ST_PASS = 4'd0;
  localparam logic [3:0] ST_TOO_LARGE = 4'd1;
  localparam logic [3:0] ST_OLD = 4'd2;
  localparam logic [3:0] ST_DUP = 4'd3;
  localparam logic [3:0] ST_BUFFERED = 4'd4;
  localparam logic [3:0] ST_DELIVERED = 4'd5;
  localparam logic [3:0] ST_GAP = 4'd6;
  localparam logic [3:0] ST_TICK = 4'd7;
  localparam logic [3:0] ST_ADVANCED = 4'd8;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input transfer
    logic rd;         // read slot at current index
    logic clr_start;  // start clearing pass
    logic clr_step;   // write zero presence, step clear index
    logic exec;       // execute command with read data
    logic scan_init;  // start expiry scan
    logic scan_step;  // test one scanned slot
    logic scan_rd;    // issue read for scan address
  } srw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic expire;     // tick caused timer expiry
    logic scan_done;
  } srw_stat_t;
endpackage

FILE: rtl/srw_ram.sv
// Generic single-port-write, one-read RAM with registered read
module srw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/srw_datapath.sv
// Datapath: slot memories, window state, counters and result register
`include "assert_macros.svh"
module srw_datapath #(
  parameter int WINDOW = srw_pkg::WINDOW_DEF,
  parameter logic [31:0] SEQ_MAX = srw_pkg::SEQ_MAX_DEF,
  parameter int MAX_PKT_BYTES = srw_pkg::MAX_PKT_DEF,
  parameter int TUNNEL_HDR_BYTES = srw_pkg::TUN_HDR_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  srw_pkg::srw_cmd_t ctl,
  output srw_pkg::srw_stat_t sts,
  input  logic [19:0]       timeout_ticks,
  input  logic [1:0]        in_cmd,
  input  logic [15:0]       in_total_len,
  input  logic [3:0]        in_header_words,
  input  logic [7:0]        in_protocol,
  input  logic [31:0]       in_epoch,
  input  logic [31:0]       in_seq,
  input  logic [15:0]       in_handle,
  output logic [3:0]        status,
  output logic [15:0]       handle_out,
  output logic [15:0]       length_out,
  output logic [31:0]       seq_out,
  output logic [31:0]       next_expected,
  output logic [31:0]       highest_received,
  output logic [31:0]       delivered_count,
  output logic [31:0]       dropped_count,
  output logic              timer_running
);
  localparam int AW = $clog2(WINDOW);
  localparam logic [15:0] MAXB = 16'(MAX_PKT_BYTES);
  localparam logic [15:0] THB = 16'(TUNNEL_HDR_BYTES);
  localparam logic [16:0] SCAN_MAX = 17'(WINDOW);

  logic [1:0]  cmd;
  logic [15:0] total_len;
  logic [3:0]  header_words;
  logic [7:0]  protocol;
  logic [31:0] epoch;
  logic [31:0] seq;
  logic [15:0] handle;
  logic [31:0] highest_epoch;
  logic [19:0] timer_count;

  logic [AW-1:0] clr_addr;
  logic          clr_last;
  logic [31:0]   scan_seq;
  logic [16:0]   scan_left;
  logic          scan_pending;

  logic          pres_we, pres_wd, pres_rd;
  logic [AW-1:0] pres_wa, rd_addr;
  logic          slot_we;
  logic [11:0]   len_rd;
  logic [15:0]   hnd_rd;
  logic [31:0]   seq_rd;

  logic [15:0] outer, inner;
  logic        bad_hdr;
  logic [AW-1:0] seq_idx, ne_idx;
  logic [19:0] limit, tc_inc;

  function automatic logic [15:0] OUTER_MIN_ADD();
    return srw_pkg::OUTER_MIN + THB;
  endfunction

  assign outer = {10'd0, header_words, 2'b00};
  assign inner = total_len - outer - THB;
  assign bad_hdr = (total_len < OUTER_MIN_ADD()) || (outer < srw_pkg::OUTER_MIN) ||
                   (outer > total_len) || (protocol != srw_pkg::TUNNEL_PROTO) ||
                   ((total_len - outer) < THB);
  assign seq_idx = seq[AW-1:0];
  assign ne_idx = next_expected[AW-1:0];
  assign limit = (timeout_ticks == 20'd0) ? 20'd1 : timeout_ticks;
  assign tc_inc = timer_count + 20'd1;

  always_comb begin
    if (ctl.scan_rd) begin
      rd_addr = scan_seq[AW-1:0];
    end else if (cmd == srw_pkg::CMD_ARRIVE) begin
      rd_addr = seq_idx;
    end else begin
      rd_addr = ne_idx;
    end
  end

  always_comb begin
    pres_we = 1'b0;
    pres_wd = 1'b0;
    pres_wa = rd_addr;
    slot_we = 1'b0;
    if (ctl.clr_step) begin
      pres_we = 1'b1;
      pres_wa = clr_addr;
    end else if (ctl.exec) begin
      if (cmd == srw_pkg::CMD_ARRIVE && !bad_hdr && inner <= MAXB &&
          !(seq < next_expected && epoch <= highest_epoch) && !pres_rd) begin
        pres_we = 1'b1;
        pres_wd = 1'b1;
        slot_we = 1'b1;
        pres_wa = seq_idx;
      end else if (cmd == srw_pkg::CMD_DELIVER && pres_rd) begin
        pres_we = 1'b1;
        pres_wa = ne_idx;
      end
    end
  end

  srw_ram #(.WIDTH(1), .DEPTH(WINDOW)) u_pres (
    .clk(clk), .we(pres_we), .waddr(pres_wa), .wdata(pres_wd),
    .raddr(rd_addr), .rdata(pres_rd));
  srw_ram #(.WIDTH(12), .DEPTH(WINDOW)) u_len (
    .clk(clk), .we(slot_we), .waddr(seq_idx), .wdata(inner[11:0]),
    .raddr(rd_addr), .rdata(len_rd));
  srw_ram #(.WIDTH(16), .DEPTH(WINDOW)) u_hnd (
    .clk(clk), .we(slot_we), .waddr(seq_idx), .wdata(handle),
    .raddr(rd_addr), .rdata(hnd_rd));
  srw_ram #(.WIDTH(32), .DEPTH(WINDOW)) u_seq (
    .clk(clk), .we(slot_we), .waddr(seq_idx), .wdata(seq),
    .raddr(rd_addr), .rdata(seq_rd));

  assign clr_last = (clr_addr == AW'(WINDOW - 1));
  assign sts.clr_done = ctl.clr_step && clr_last;
  assign sts.expire = (cmd == srw_pkg::CMD_TICK) && timer_running && (tc_inc >= limit);
  assign sts.scan_done = !scan_pending || (ctl.scan_step && (pres_rd || scan_left == 17'd1));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= in_cmd;
      total_len <= in_total_len;
      header_words <= in_header_words;
      protocol <= in_protocol;
      epoch <= in_epoch;
      seq <= in_seq;
      handle <= in_handle;
    end
    if (ctl.scan_init) begin
      scan_seq <= next_expected;
      scan_pending <= next_expected <= highest_received;
      scan_left <= ((highest_received - next_expected) >= 32'(WINDOW - 1)) ? SCAN_MAX
                   : 17'(highest_received - next_expected) + 17'd1;
    end else if (ctl.scan_step) begin
      scan_seq <= scan_seq + 32'd1;
      scan_left <= scan_left - 17'd1;
    end
    if (rst) begin
      clr_addr <= '0;
      next_expected <= '0;
      highest_received <= '0;
      highest_epoch <= '0;
      timer_running <= 1'b0;
      timer_count <= '0;
      delivered_count <= '0;
      dropped_count <= '0;
    end else begin
      if (ctl.clr_start) begin
        clr_addr <= '0;
      end else if (ctl.clr_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (ctl.scan_step && scan_pending && pres_rd) begin
        next_expected <= scan_seq;
      end
      if (ctl.exec) begin
        status <= srw_pkg::ST_PASS;
        handle_out <= '0;
        length_out <= '0;
        seq_out <= '0;
        case (cmd)
          srw_pkg::CMD_ARRIVE: begin
            if (bad_hdr) begin
              handle_out <= handle;
              length_out <= total_len;
            end else if (inner > MAXB) begin
              dropped_count <= dropped_count + 32'd1;
              status <= srw_pkg::ST_TOO_LARGE;
            end else if (seq < next_expected && epoch <= highest_epoch) begin
              delivered_count <= delivered_count + 32'd1;
              status <= srw_pkg::ST_OLD;
              handle_out <= handle;
              length_out <= inner;
              seq_out <= seq;
            end else if (pres_rd) begin
              dropped_count <= dropped_count + 32'd1;
              status <= srw_pkg::ST_DUP;
            end else begin
              status <= srw_pkg::ST_BUFFERED;
              if (epoch == highest_epoch) begin
                if (seq > highest_received) begin
                  highest_received <= seq;
                end
              end else if (epoch > highest_epoch) begin
                highest_epoch <= epoch;
                highest_received <= seq;
              end
            end
          end
          srw_pkg::CMD_DELIVER: begin
            if (!pres_rd) begin
              status <= srw_pkg::ST_GAP;
              if (next_expected <= highest_received && !timer_running) begin
                timer_running <= 1'b1;
                timer_count <= '0;
              end
            end else begin
              if (next_expected == highest_received) begin
                timer_running <= 1'b0;
              end
              handle_out <= hnd_rd;
              length_out <= {4'd0, len_rd};
              seq_out <= seq_rd;
              next_expected <= (next_expected == SEQ_MAX) ? 32'd0 : next_expected + 32'd1;
              delivered_count <= delivered_count + 32'd1;
              status <= srw_pkg::ST_DELIVERED;
            end
          end
          srw_pkg::CMD_TICK: begin
            status <= srw_pkg::ST_TICK;
            if (timer_running) begin
              if (tc_inc >= limit) begin
                timer_count <= '0;
                status <= srw_pkg::ST_ADVANCED;
              end else begin
                timer_count <= tc_inc;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  `ASSERT_NEXT(a_clr_wraps, clk, rst, ctl.clr_step && clr_last, clr_addr == '0,
               "clear index did not wrap")
  `ASSERT_IMPL(a_scan_left, clk, rst, ctl.scan_step && scan_pending, scan_left != 17'd0,
               "scan past window")
endmodule

FILE: rtl/srw_ctrl.sv
// Controller: clearing pass, command sequencing, expiry scan and output handshake
`include "assert_macros.svh"
module srw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output srw_pkg::srw_cmd_t  ctl,
  input  srw_pkg::srw_stat_t sts
);
  typedef enum logic [2:0] {
    CLEAR, IDLE, READ, EXEC, SCAN_RD, SCAN, OUT
  } state_t;
  state_t state;

  assign s_axis_tready = (state == IDLE);

  always_comb begin
    ctl = '0;
    ctl.load = (state == IDLE) && s_axis_tvalid;
    ctl.rd = (state == READ);
    ctl.clr_step = (state == CLEAR);
    ctl.exec = (state == EXEC);
    ctl.scan_init = (state == EXEC) && sts.expire;
    ctl.scan_rd = (state == SCAN_RD) || (state == SCAN);
    ctl.scan_step = (state == SCAN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        CLEAR: if (sts.clr_done) state <= IDLE;
        IDLE: if (s_axis_tvalid) state <= READ;
        READ: state <= EXEC;
        EXEC: begin
          if (sts.expire) begin
            state <= SCAN_RD;
          end else begin
            state <= OUT;
            m_axis_tvalid <= 1'b1;
          end
        end
        SCAN_RD: state <= SCAN;
        SCAN: begin
          if (sts.scan_done) begin
            state <= OUT;
            m_axis_tvalid <= 1'b1;
          end else begin
            state <= SCAN_RD;
          end
        end
        OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_valid_out, clk, rst, m_axis_tvalid, state == OUT, "valid outside OUT")
  `ASSERT_IMPL(a_no_take, clk, rst, s_axis_tready, !m_axis_tvalid, "input while result pending")
endmodule

FILE: rtl/sequence_reorder_window.sv
// Top level: reorder window for tunnelled sequence-numbered packets
// Usage:
//   Slave stream carries one command per transfer (arrive, deliver, tick).
//   Master stream returns exactly one result per command.
//   Configuration: timeout_wr/timeout_data write the reorder timeout at any idle time.
// Sequencing:
//   Arrive, deliver and non-expiring tick: an accepted command passes
//   through READ and EXEC, and the result is then held valid in OUT until
//   taken before the return to IDLE. One item is processed at a time.
//   Expiring tick: adds a SCAN_RD and SCAN pass per scanned slot, a pass
//   even when nothing is scanned, up to WINDOW slots, set by the single
//   read port of the slot presence memory.
// Reset:
//   Synchronous rst clears all counters and window state, then a clearing
//   pass zeroes slot presence, one entry a cycle across all WINDOW entries, with
//   s_axis_tready low throughout.
// Stall:
//   While a result waits for m_axis_tready the result holds and no new
//   input transfer is taken.
module sequence_reorder_window #(
  parameter int WINDOW = srw_pkg::WINDOW_DEF,
  parameter logic [31:0] SEQ_MAX = srw_pkg::SEQ_MAX_DEF,
  parameter int MAX_PKT_BYTES = srw_pkg::MAX_PKT_DEF,
  parameter int TUNNEL_HDR_BYTES = srw_pkg::TUN_HDR_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         timeout_wr,
  input  logic [19:0]  timeout_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // total_len[15:0], header_words[19:16], protocol[27:20], epoch[59:28],
  // seq_in[91:60], buffer_handle[107:92], zero fill
  input  logic [111:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // handle_out[15:0], length_out[31:16], seq_out[63:32],
  // next_expected_out[95:64], highest_received_out[127:96],
  // delivered_total[159:128], dropped_total[191:160], timer_on[192], zero fill
  output logic [199:0] m_axis_tdata,
  // status[3:0]
  output logic [3:0]   m_axis_tuser
);
  srw_pkg::srw_cmd_t  ctl;
  srw_pkg::srw_stat_t sts;
  logic [19:0] timeout_ticks;
  logic [15:0] handle_out, length_out;
  logic [31:0] seq_out, ne, hr, dc, dr;
  logic        tr;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= srw_pkg::TIMEOUT_RESET;
    end else if (timeout_wr) begin
      timeout_ticks <= timeout_data;
    end
  end

  srw_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .ctl(ctl), .sts(sts));

  srw_datapath #(
    .WINDOW(WINDOW), .SEQ_MAX(SEQ_MAX),
    .MAX_PKT_BYTES(MAX_PKT_BYTES), .TUNNEL_HDR_BYTES(TUNNEL_HDR_BYTES)
  ) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .timeout_ticks(timeout_ticks),
    .in_cmd(s_axis_tuser),
    .in_total_len(s_axis_tdata[15:0]),
    .in_header_words(s_axis_tdata[19:16]),
    .in_protocol(s_axis_tdata[27:20]),
    .in_epoch(s_axis_tdata[59:28]),
    .in_seq(s_axis_tdata[91:60]),
    .in_handle(s_axis_tdata[107:92]),
    .status(m_axis_tuser),
    .handle_out(handle_out), .length_out(length_out), .seq_out(seq_out),
    .next_expected(ne), .highest_received(hr),
    .delivered_count(dc), .dropped_count(dr), .timer_running(tr));

  assign m_axis_tdata = {7'd0, tr, dr, dc, hr, ne, seq_out, length_out, handle_out};
endmodule

FILE: dv/tb_sequence_reorder_window.sv
// Testbench for sequence_reorder_window: stream driver, result checker and reorder predictor
module tb_sequence_reorder_window;
  localparam int SLOTS = 1024;
  localparam int TUN_HDR = 16;
  localparam int MAX_PKT = 2048;
  localparam longint LIMIT = 10000000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] total_len;
    logic [3:0]  header_words;
    logic [7:0]  protocol;
    logic [31:0] epoch;
    logic [31:0] seq_in;
    logic [15:0] buffer_handle;
  } pkt_cmd_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] handle_out;
    logic [15:0] length_out;
    logic [31:0] seq_out;
    logic [31:0] next_exp;
    logic [31:0] high_rcv;
    logic [31:0] delivered;
    logic [31:0] dropped;
    logic        timer_on;
  } reorder_res_t;

  logic clk = 0;
  logic rst = 1;
  logic timeout_wr = 0;
  logic [19:0] timeout_data = '0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [199:0] m_axis_tdata;
  logic [3:0] m_axis_tuser;

  sequence_reorder_window dut (.*);

  initial forever #5 clk = ~clk;

  // predictor state
  logic        slot_valid [SLOTS];
  logic [11:0] slot_len [SLOTS];
  logic [15:0] slot_hdl [SLOTS];
  logic [31:0] slot_sn [SLOTS];
  logic [31:0] next_exp, high_rcv, high_epoch, delivered, dropped;
  logic        tmr_on;
  logic [19:0] tmr_cnt, tmo_ticks;

  pkt_cmd_t     pending_cmds[$];
  reorder_res_t expected_res[$];
  int send_idle, recv_idle, errors;
  logic hold_arm = 0;
  logic hold_done = 0;
  int hold_left = 0;
  longint cycles = 0;
  logic [31:0] gen_cur, gen_epoch;

  task automatic reorder_step(input pkt_cmd_t c, output reorder_res_t r);
    logic [31:0] outer, inner, tl, start, s;
    logic [9:0] idx;
    longint n;
    logic [19:0] lim;
    r = '0;
    tl = {16'd0, c.total_len};
    case (c.cmd)
      srw_pkg::CMD_ARRIVE: begin
        outer = {26'd0, c.header_words, 2'b00};
        if (tl < 32'(srw_pkg::OUTER_MIN) + TUN_HDR || outer < 32'(srw_pkg::OUTER_MIN) ||
            outer > tl || c.protocol != srw_pkg::TUNNEL_PROTO || tl - outer < TUN_HDR) begin
          r.status = srw_pkg::ST_PASS;
          r.handle_out = c.buffer_handle;
          r.length_out = c.total_len;
        end else begin
          inner = tl - outer - TUN_HDR;
          idx = c.seq_in[9:0];
          if (inner > MAX_PKT) begin
            dropped++;
            r.status = srw_pkg::ST_TOO_LARGE;
          end else if (c.seq_in < next_exp && c.epoch <= high_epoch) begin
            delivered++;
            r.status = srw_pkg::ST_OLD;
            r.handle_out = c.buffer_handle;
            r.length_out = inner[15:0];
            r.seq_out = c.seq_in;
          end else if (slot_valid[idx]) begin
            dropped++;
            r.status = srw_pkg::ST_DUP;
          end else begin
            slot_len[idx] = inner[11:0];
            slot_hdl[idx] = c.buffer_handle;
            slot_sn[idx] = c.seq_in;
            slot_valid[idx] = 1;
            if (c.epoch == high_epoch) begin
              if (c.seq_in > high_rcv) high_rcv = c.seq_in;
            end else if (c.epoch > high_epoch) begin
              high_epoch = c.epoch;
              high_rcv = c.seq_in;
            end
            r.status = srw_pkg::ST_BUFFERED;
          end
        end
      end
      srw_pkg::CMD_DELIVER: begin
        start = next_exp;
        idx = start[9:0];
        if (!slot_valid[idx]) begin
          if (start <= high_rcv && !tmr_on) begin
            tmr_on = 1;
            tmr_cnt = '0;
          end
          r.status = srw_pkg::ST_GAP;
        end else begin
          if (start == high_rcv) tmr_on = 0;
          slot_valid[idx] = 0;
          r.handle_out = slot_hdl[idx];
          r.length_out = {4'd0, slot_len[idx]};
          r.seq_out = slot_sn[idx];
          next_exp = (start == srw_pkg::SEQ_MAX_DEF) ? 32'd0 : start + 1;
          delivered++;
          r.status = srw_pkg::ST_DELIVERED;
        end
      end
      srw_pkg::CMD_TICK: begin
        r.status = srw_pkg::ST_TICK;
        if (tmr_on) begin
          lim = (tmo_ticks == 0) ? 20'd1 : tmo_ticks;
          tmr_cnt = tmr_cnt + 1;
          if (tmr_cnt >= lim) begin
            tmr_cnt = '0;
            r.status = srw_pkg::ST_ADVANCED;
            start = next_exp;
            if (start <= high_rcv) begin
              n = longint'(high_rcv) - longint'(start) + 1;
              if (n > SLOTS) n = SLOTS;
              for (longint i = 0; i < n; i++) begin
                s = start + 32'(i);
                if (slot_valid[s[9:0]]) begin
                  next_exp = s;
                  break;
                end
              end
            end
          end
        end
      end
      default: r.status = srw_pkg::ST_PASS;
    endcase
    r.next_exp = next_exp;
    r.high_rcv = high_rcv;
    r.delivered = delivered;
    r.dropped = dropped;
    r.timer_on = tmr_on;
  endtask

  initial begin
    foreach (slot_valid[i]) slot_valid[i] = 0;
    next_exp = 0; high_rcv = 0; high_epoch = 0; delivered = 0; dropped = 0;
    tmr_on = 0; tmr_cnt = 0; tmo_ticks = srw_pkg::TIMEOUT_RESET;
  end

  // driver
  always @(posedge clk) begin
    reorder_res_t r;
    if (rst) begin
      s_axis_tvalid <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        reorder_step(pending_cmds.pop_front(), r);
        expected_res.push_back(r);
      end
      if (s_axis_tvalid && !s_axis_tready) begin
      end else if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle) begin
        s_axis_tvalid <= 1;
        s_axis_tdata <= {4'd0, pending_cmds[0].buffer_handle, pending_cmds[0].seq_in,
                         pending_cmds[0].epoch, pending_cmds[0].protocol,
                         pending_cmds[0].header_words, pending_cmds[0].total_len};
        s_axis_tuser <= pending_cmds[0].cmd;
      end else begin
        s_axis_tvalid <= 0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_arm && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch expected %h actual %h", $time, name, e, a);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    reorder_res_t e;
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb_sequence_reorder_window: FAIL");
      $finish;
    end
    m_axis_tready <= !rst && hold_left == 0 && $urandom_range(99) >= recv_idle;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected transfer status %0d", $time, m_axis_tuser);
        errors++;
      end else begin
        e = expected_res.pop_front();
        check_field("status", 32'(e.status), 32'(m_axis_tuser));
        check_field("handle_out", 32'(e.handle_out), 32'(m_axis_tdata[15:0]));
        check_field("length_out", 32'(e.length_out), 32'(m_axis_tdata[31:16]));
        check_field("seq_out", e.seq_out, m_axis_tdata[63:32]);
        check_field("next_expected", e.next_exp, m_axis_tdata[95:64]);
        check_field("highest_received", e.high_rcv, m_axis_tdata[127:96]);
        check_field("delivered_total", e.delivered, m_axis_tdata[159:128]);
        check_field("dropped_total", e.dropped, m_axis_tdata[191:160]);
        check_field("timer_on", 32'(e.timer_on), 32'(m_axis_tdata[192]));
      end
    end
  end

  function automatic pkt_cmd_t mk(input logic [1:0] cmd, input logic [15:0] tl,
                                  input logic [3:0] hw, input logic [7:0] pr,
                                  input logic [31:0] ep, input logic [31:0] sq,
                                  input logic [15:0] hd);
    pkt_cmd_t c;
    c = '{cmd, tl, hw, pr, ep, sq, hd};
    return c;
  endfunction

  function automatic pkt_cmd_t good_pkt(input logic [31:0] ep, input logic [31:0] sq,
                                        input int inner);
    int hw;
    hw = ($urandom_range(3) == 0) ? $urandom_range(15, 5) : 5;
    return mk(srw_pkg::CMD_ARRIVE, 16'(hw * 4 + TUN_HDR + inner), 4'(hw),
              srw_pkg::TUNNEL_PROTO, ep, sq, 16'($urandom));
  endfunction

  task automatic fill_random(input int count);
    int k, inner;
    pkt_cmd_t c;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      if (k < 40) begin
        inner = ($urandom_range(19) == 0) ? $urandom_range(4000, 2049) :
                $urandom_range(MAX_PKT);
        if ($urandom_range(49) == 0) gen_epoch++;
        c = good_pkt(gen_epoch, gen_cur + $urandom_range(24) - 8, inner);
        if ($urandom_range(9) == 0) c.epoch = gen_epoch - 1;
        gen_cur++;
      end else if (k < 48) begin
        c = mk(2'($urandom_range(3)), 16'($urandom), 4'($urandom), 8'($urandom),
               $urandom, $urandom, 16'($urandom));
        if ($urandom_range(1)) c.protocol = srw_pkg::TUNNEL_PROTO;
      end else if (k < 85) begin
        c = mk(srw_pkg::CMD_DELIVER, 16'($urandom), 4'($urandom), 8'($urandom),
               $urandom, $urandom, 16'($urandom));
      end else begin
        c = mk(srw_pkg::CMD_TICK, 16'($urandom), 4'($urandom), 8'($urandom),
               $urandom, $urandom, 16'($urandom));
      end
      pending_cmds.push_back(c);
    end
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || expected_res.size() > 0 || s_axis_tvalid)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [19:0] v);
    @(posedge clk);
    timeout_wr <= 1;
    timeout_data <= v;
    tmo_ticks = v;
    @(posedge clk);
    timeout_wr <= 0;
  endtask

  initial begin
    logic [19:0] tmo_list [5];
    errors = 0;
    send_idle = 30;
    recv_idle = 88;
    gen_cur = 3;
    gen_epoch = 1;
    tmo_list = '{20'd100, 20'd0, 20'd3, 20'hFFFFF, 20'd1};
    repeat (3) @(posedge clk);
    rst <= 0;

    // header checks, drops, in-order and old delivery, timer start
    pending_cmds.push_back(mk(srw_pkg::CMD_ARRIVE, 16'd35, 4'd5, srw_pkg::TUNNEL_PROTO,
                              0, 0, 16'h1234));
    pending_cmds.push_back(mk(srw_pkg::CMD_ARRIVE, 16'd100, 4'd4, srw_pkg::TUNNEL_PROTO,
                              0, 0, 16'h0001));
    pending_cmds.push_back(mk(srw_pkg::CMD_ARRIVE, 16'd40, 4'd15, srw_pkg::TUNNEL_PROTO,
                              0, 0, 16'h0002));
    pending_cmds.push_back(mk(srw_pkg::CMD_ARRIVE, 16'd100, 4'd5, 8'd17, 0, 0, 16'h0003));
    pending_cmds.push_back(mk(srw_pkg::CMD_ARRIVE, 16'd70, 4'd15, srw_pkg::TUNNEL_PROTO,
                              0, 0, 16'h0004));
    pending_cmds.push_back(mk(srw_pkg::CMD_ARRIVE, 16'd2085, 4'd5, srw_pkg::TUNNEL_PROTO,
                              0, 0, 16'h0005));
    pending_cmds.push_back(mk(srw_pkg::CMD_ARRIVE, 16'hFFFF, 4'd15, 8'hFF, 32'hFFFFFFFF,
                              32'hFFFFFFFF, 16'hFFFF));
    pending_cmds.push_back(mk(srw_pkg::CMD_ARRIVE, 16'hFFFF, 4'd15, srw_pkg::TUNNEL_PROTO,
                              0, 0, 16'hFFFF));
    pending_cmds.push_back(mk(srw_pkg::CMD_ARRIVE, 16'd2084, 4'd5, srw_pkg::TUNNEL_PROTO,
                              0, 0, 16'hFFFF));
    pending_cmds.push_back(mk(srw_pkg::CMD_ARRIVE, 16'd36, 4'd5, srw_pkg::TUNNEL_PROTO,
                              0, 0, 16'h0006));
    pending_cmds.push_back(mk(srw_pkg::CMD_DELIVER, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(srw_pkg::CMD_DELIVER, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(srw_pkg::CMD_ARRIVE, 16'd100, 4'd5, srw_pkg::TUNNEL_PROTO,
                              0, 0, 16'h0007));
    pending_cmds.push_back(mk(srw_pkg::CMD_ARRIVE, 16'd100, 4'd5, srw_pkg::TUNNEL_PROTO,
                              1, 2, 16'h0008));
    pending_cmds.push_back(mk(srw_pkg::CMD_DELIVER, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(srw_pkg::CMD_DELIVER, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(srw_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(2'd3, 16'hFFFF, 4'hF, 8'hFF, '1, '1, 16'hFFFF));
    pending_cmds.push_back(mk(srw_pkg::CMD_ARRIVE, 16'd100, 4'd5, srw_pkg::TUNNEL_PROTO,
                              1, 1, 16'h0009));
    pending_cmds.push_back(mk(srw_pkg::CMD_DELIVER, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(srw_pkg::CMD_DELIVER, 0, 0, 0, 0, 0, 0));

    for (int p = 0; p < 5; p++) begin
      if (p == 2) begin
        send_idle = 88;
        recv_idle = 30;
      end else if (p == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (p > 0) set_timeout(tmo_list[p]);
      fill_random(140);
      if (p == 4) begin
        hold_arm <= 1;
        pending_cmds.push_back(mk(srw_pkg::CMD_ARRIVE, 16'd100, 4'd5, srw_pkg::TUNNEL_PROTO,
                                  32'hFFFFFFFF, 32'hFFFFFFFF, 16'h00AA));
        pending_cmds.push_back(mk(srw_pkg::CMD_DELIVER, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(srw_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0));
      end
      wait_drained();
    end

    if (errors == 0 && expected_res.size() == 0)
      $display("tb_sequence_reorder_window: PASS");
    else
      $display("tb_sequence_reorder_window: FAIL");
    $finish;
  end
endmodule
